// ===== hw/rtl/salru_pkg.sv =====
package salru_pkg;

	localparam int SETS       = 32;
	localparam int WAYS       = 4;
	localparam int TAG_BITS   = 15;
	localparam int FRAME_BITS = 16;
	localparam int SET_BITS   = $clog2(SETS);
	localparam int WAY_BITS   = $clog2(WAYS);
	localparam int LRU_BITS   = WAYS * WAYS;
	// Metadata word: valid bits in the low part, the LRU matrix above them.
	localparam int META_BITS  = WAYS + LRU_BITS;
	localparam int ROW_BITS   = WAYS * TAG_BITS;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_FILL   = 1'b1;

	typedef struct packed {
		logic                  hit;
		logic [WAY_BITS-1:0]   way;
		logic                  write_through;
		logic [FRAME_BITS-1:0] write_frame;
		logic                  evicted_valid;
		logic [TAG_BITS-1:0]   evicted_tag;
		logic                  meta_we;
		logic                  tag_we;
		logic [META_BITS-1:0]  meta_next;
		logic [ROW_BITS-1:0]   tags_next;
	} upd_t;

endpackage

// ===== hw/rtl/salru_ram.sv =====
module salru_ram #(
	parameter int DEPTH     = 32,
	parameter int WIDTH     = 8,
	parameter int ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/salru_update.sv =====
module salru_update (
	input  logic                           op,
	input  logic [salru_pkg::TAG_BITS-1:0]   tag,
	input  logic                           is_write,
	input  logic [salru_pkg::FRAME_BITS-1:0] frame,
	input  logic [salru_pkg::META_BITS-1:0]  meta,
	input  logic [salru_pkg::ROW_BITS-1:0]   tags,
	output salru_pkg::upd_t                 upd
);
	import salru_pkg::*;

	logic [WAYS-1:0]     valid;
	logic [LRU_BITS-1:0] lru;
	logic [WAYS-1:0]     match;
	logic                any_hit;
	logic [WAY_BITS-1:0] hit_way;
	logic                any_free;
	logic [WAY_BITS-1:0] free_way;
	logic [WAY_BITS-1:0] lru_way;
	logic [WAY_BITS-1:0] sel_way;
	logic [WAY_BITS-1:0] victim;
	logic [LRU_BITS-1:0] lru_next;
	logic [WAYS-1:0]     valid_next;

	assign valid = meta[WAYS-1:0];
	assign lru   = meta[META_BITS-1:WAYS];

	always_comb begin
		match    = '0;
		any_hit  = 1'b0;
		hit_way  = '0;
		any_free = 1'b0;
		free_way = '0;
		lru_way  = '0;
		// Walk downward so the lowest-numbered candidate wins.
		for (int w = WAYS - 1; w >= 0; w--) begin
			match[w] = valid[w] && (tags[w*TAG_BITS +: TAG_BITS] == tag);
			if (match[w]) begin
				any_hit = 1'b1;
				hit_way = WAY_BITS'(w);
			end
			if (!valid[w]) begin
				any_free = 1'b1;
				free_way = WAY_BITS'(w);
			end
			if (lru[w*WAYS +: WAYS] == '0) begin
				lru_way = WAY_BITS'(w);
			end
		end
	end

	assign victim  = any_free ? free_way : lru_way;
	assign sel_way = (op == OP_FILL) ? victim : hit_way;

	always_comb begin
		lru_next = lru;
		lru_next[sel_way*WAYS +: WAYS] = '1;
		for (int r = 0; r < WAYS; r++) begin
			lru_next[r*WAYS + int'(sel_way)] = 1'b0;
		end
		valid_next = valid;
		if (op == OP_FILL) begin
			valid_next[victim] = 1'b1;
		end
	end

	always_comb begin
		upd = '0;
		upd.meta_next = {lru_next, valid_next};
		upd.tags_next = tags;
		upd.tags_next[victim*TAG_BITS +: TAG_BITS] = tag;
		unique case (op)
			OP_LOOKUP: begin
				if (any_hit) begin
					upd.hit           = 1'b1;
					upd.way           = hit_way;
					upd.write_through = is_write;
					upd.write_frame   = is_write ? frame : '0;
					upd.meta_we       = 1'b1;
				end
			end
			OP_FILL: begin
				upd.way           = victim;
				upd.evicted_valid = !any_free;
				upd.evicted_tag   = any_free ? '0 : tags[victim*TAG_BITS +: TAG_BITS];
				upd.meta_we       = 1'b1;
				upd.tag_we        = 1'b1;
			end
			default: begin
				upd = '0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/set_assoc_tag_store_matrix_lru_top.sv =====
// Tag store of a four-way set-associative write-through cache with matrix LRU.
// The input channel (in_valid / in_ready) carries one item: a lookup or a fill,
// the set, the tag, the write flag and the frame number. Every item yields
// exactly one result on the output channel (out_valid / out_ready): hit and
// way, the write-through request with its frame, and the evicted tag of a fill.
// For every item, the accepting edge reads the set's tag row and its
// metadata word (valid bits and LRU matrix) from two synchronous memories, and
// once the result register is free, the updated row is written back and the
// result register is loaded. A new item is accepted only after that write-back,
// since the read-modify-write of the set's memory entry must finish first.
// Because the write-back lands before the next read, items to the same set
// need no forwarding.
// Reset clears the valid bits and LRU matrices at once through one
// initialized flag per set; the tag memory is not cleared.
// When the receiver stalls, the result register holds its item and one more
// item may be accepted and read; it then waits until the register frees.
module set_assoc_tag_store_matrix_lru_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             operation,
	input  logic [salru_pkg::SET_BITS-1:0]   set_index,
	input  logic [salru_pkg::TAG_BITS-1:0]   tag,
	input  logic                             is_write,
	input  logic [salru_pkg::FRAME_BITS-1:0] frame_id,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             hit,
	output logic [salru_pkg::WAY_BITS-1:0]   way,
	output logic                             write_through,
	output logic [salru_pkg::FRAME_BITS-1:0] write_frame,
	output logic                             evicted_valid,
	output logic [salru_pkg::TAG_BITS-1:0]   evicted_tag
);
	import salru_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_LOOK = 1'b1;

	logic                  state_q;
	logic                  accept;
	logic                  done;
	logic                  op_s1;
	logic [SET_BITS-1:0]   set_s1;
	logic [TAG_BITS-1:0]   tag_s1;
	logic                  wr_s1;
	logic [FRAME_BITS-1:0] frame_s1;
	logic                  meta_ok_s1;
	logic [SETS-1:0]       init_q;
	logic [META_BITS-1:0]  meta_rd;
	logic [META_BITS-1:0]  meta_eff;
	logic [ROW_BITS-1:0]   tags_rd;
	logic                  meta_we;
	logic                  tag_we;
	logic                  out_valid_q;
	upd_t                  upd;
	upd_t                  res_q;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign done     = (state_q == S_LOOK) && (!out_valid_q || out_ready);
	assign meta_we  = done && upd.meta_we;
	assign tag_we   = done && upd.tag_we;
	// A set never written since reset reads as all invalid with a clear matrix.
	assign meta_eff = meta_ok_s1 ? meta_rd : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			init_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					if (done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (meta_we) begin
				init_q[set_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= operation;
			set_s1     <= set_index;
			tag_s1     <= tag;
			wr_s1      <= is_write;
			frame_s1   <= frame_id;
			meta_ok_s1 <= init_q[set_index];
		end
		if (done) begin
			res_q <= upd;
		end
	end

	salru_ram #(
		.DEPTH(SETS),
		.WIDTH(ROW_BITS)
	) u_tag_ram (
		.clk  (clk),
		.we   (tag_we),
		.waddr(set_s1),
		.wdata(upd.tags_next),
		.re   (accept),
		.raddr(set_index),
		.rdata(tags_rd)
	);

	salru_ram #(
		.DEPTH(SETS),
		.WIDTH(META_BITS)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(set_s1),
		.wdata(upd.meta_next),
		.re   (accept),
		.raddr(set_index),
		.rdata(meta_rd)
	);

	salru_update u_update (
		.op      (op_s1),
		.tag     (tag_s1),
		.is_write(wr_s1),
		.frame   (frame_s1),
		.meta    (meta_eff),
		.tags    (tags_rd),
		.upd     (upd)
	);

	assign out_valid     = out_valid_q;
	assign hit           = res_q.hit;
	assign way           = res_q.way;
	assign write_through = res_q.write_through;
	assign write_frame   = res_q.write_frame;
	assign evicted_valid = res_q.evicted_valid;
	assign evicted_tag   = res_q.evicted_tag;

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_LOOK)
		else $error("accepted item did not enter the lookup state");

	a_result_from_look: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_LOOK)
		else $error("result appeared without a lookup");

	a_meta_write_in_look: assert property (@(posedge clk) disable iff (!arst_n)
		(meta_we || tag_we) |-> state_q == S_LOOK && !in_ready)
		else $error("memory write outside the lookup state");

	a_wt_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(write_through && !hit) && !(hit && evicted_valid))
		else $error("inconsistent result fields");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q &&
			$stable({hit, way, write_through, write_frame, evicted_valid, evicted_tag}))
		else $error("stalled result changed");

endmodule
